// ===== design/ipv4hc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, field constants and verdict codes for the ipv4 receive header check
// no dependencies; imported by ipv4hc_frame and ipv4_rx_header_check
package ipv4hc_pkg;

    // frame byte counter width and its saturation value
    localparam int COUNT_W = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // protocol constants
    localparam logic [COUNT_W-1:0] ETH_HDR_LEN      = COUNT_W'(14);
    localparam logic [5:0]         IP_MIN_HDR_LEN   = 6'd20;
    localparam logic [3:0]         IPV4_VERSION     = 4'd4;
    localparam logic [15:0]        FRAG_OFFSET_MASK = 16'h1FFF;
    localparam logic [15:0]        FRAG_MORE_BIT    = 16'h2000;
    localparam logic [15:0]        FRAG_DONT_BIT    = 16'h4000;
    localparam logic               HOST_FOREIGN     = 1'b1;

    // verdict codes
    localparam logic [3:0] ST_WHOLE_OK  = 4'd0;
    localparam logic [3:0] ST_FRAG_OK   = 4'd1;
    localparam logic [3:0] ST_NOT_OURS  = 4'd2;
    localparam logic [3:0] ST_SHORT     = 4'd3;
    localparam logic [3:0] ST_NOT_V4    = 4'd4;
    localparam logic [3:0] ST_HDR_SMALL = 4'd5;
    localparam logic [3:0] ST_CHECKSUM  = 4'd6;
    localparam logic [3:0] ST_LEN_BAD   = 4'd7;
    localparam logic [3:0] ST_DF_FRAG   = 4'd8;

    // one received frame byte
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last;
        logic       other_host;
    } ipv4hc_in_t;

    // one verdict word
    typedef struct packed {
        logic [3:0]  status;
        logic [16:0] kept_length;
        logic [5:0]  header_bytes;
    } ipv4hc_out_t;

endpackage

// ===== design/ipv4hc_frame.sv =====
`timescale 1ns / 1ps
// per-frame state: byte count, header field capture, ones' complement sum, verdict
// depends on ipv4hc_pkg
module ipv4hc_frame (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  ipv4hc_pkg::ipv4hc_in_t  word,
    output ipv4hc_pkg::ipv4hc_out_t verdict
);
    import ipv4hc_pkg::*;

    // byte offsets inside the ip header
    localparam logic [COUNT_W-1:0] OFS_VER_IHL = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] OFS_TLEN_HI = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] OFS_TLEN_LO = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] OFS_FRAG_HI = COUNT_W'(6);
    localparam logic [COUNT_W-1:0] OFS_FRAG_LO = COUNT_W'(7);
    localparam logic [COUNT_W-1:0] MIN_FRAME   = ETH_HDR_LEN + COUNT_W'(IP_MIN_HDR_LEN);

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next, count_upd;
    logic [15:0]        sum_acc_reg, sum_acc_next, sum_upd;
    logic [7:0]         high_byte_reg, high_byte_next, high_upd;
    logic [7:0]         version_ihl_reg, version_ihl_next, version_upd;
    logic [15:0]        total_len_reg, total_len_next, total_upd;
    logic [15:0]        frag_word_reg, frag_word_next, frag_upd;
    logic               foreign_flag_reg, foreign_flag_next, foreign_upd;

    logic [COUNT_W-1:0] ip_idx;
    logic [5:0]         hlen;
    logic [16:0]        word_sum;
    logic [15:0]        oc_sum;
    logic [COUNT_W-1:0] hdr_end;
    logic [COUNT_W-1:0] kept;

    // end-around carry add of one header word
    assign word_sum = {1'b0, sum_acc_reg} + {1'b0, high_byte_reg, word.frame_byte};
    assign oc_sum   = word_sum[15:0] + {15'd0, word_sum[16]};

    assign ip_idx = byte_count_reg - ETH_HDR_LEN;

    // version/ihl byte, taken ahead of the rest since the header length hangs on it
    assign version_upd = ((byte_count_reg >= ETH_HDR_LEN) && (ip_idx == OFS_VER_IHL))
                         ? word.frame_byte : version_ihl_reg;
    assign hlen        = {version_upd[3:0], 2'b00};

    // field capture and header sum for the current byte
    always_comb
    begin
        count_upd   = (byte_count_reg == COUNT_MAX) ? COUNT_MAX
                                                    : byte_count_reg + COUNT_W'(1);
        sum_upd     = sum_acc_reg;
        high_upd    = high_byte_reg;
        total_upd   = total_len_reg;
        frag_upd    = frag_word_reg;
        foreign_upd = foreign_flag_reg;

        if (byte_count_reg == '0)
        begin
            foreign_upd = (word.other_host == HOST_FOREIGN);
        end

        if (byte_count_reg >= ETH_HDR_LEN)
        begin
            case (ip_idx)
                OFS_TLEN_HI: total_upd = {word.frame_byte, total_len_reg[7:0]};
                OFS_TLEN_LO: total_upd = {total_len_reg[15:8], word.frame_byte};
                OFS_FRAG_HI: frag_upd  = {word.frame_byte, frag_word_reg[7:0]};
                OFS_FRAG_LO: frag_upd  = {frag_word_reg[15:8], word.frame_byte};
                default:     ;
            endcase
            if (ip_idx < COUNT_W'(hlen))
            begin
                if (!ip_idx[0])
                begin
                    high_upd = word.frame_byte;
                end
                else
                begin
                    sum_upd = oc_sum;
                end
            end
        end
    end

    // verdict from the state as it stands after this byte
    assign hdr_end = ETH_HDR_LEN + COUNT_W'(hlen);
    assign kept    = ETH_HDR_LEN + COUNT_W'(total_upd);

    always_comb
    begin
        if (foreign_upd)
            verdict.status = ST_NOT_OURS;
        else if (count_upd < MIN_FRAME)
            verdict.status = ST_SHORT;
        else if (version_upd[7:4] != IPV4_VERSION)
            verdict.status = ST_NOT_V4;
        else if (hlen < IP_MIN_HDR_LEN)
            verdict.status = ST_HDR_SMALL;
        else if (count_upd < hdr_end)
            verdict.status = ST_SHORT;
        else if (sum_upd != 16'hFFFF)
            verdict.status = ST_CHECKSUM;
        else if ((total_upd < {10'd0, hlen}) || (count_upd < kept))
            verdict.status = ST_LEN_BAD;
        else if ((frag_upd & (FRAG_OFFSET_MASK | FRAG_MORE_BIT)) != 16'd0)
            verdict.status = ((frag_upd & FRAG_DONT_BIT) != 16'd0) ? ST_DF_FRAG : ST_FRAG_OK;
        else
            verdict.status = ST_WHOLE_OK;

        verdict.kept_length  = ((verdict.status == ST_WHOLE_OK) ||
                                (verdict.status == ST_FRAG_OK)) ? kept : '0;
        verdict.header_bytes = hlen;
    end

    // state returns to reset values after the last byte
    always_comb
    begin
        byte_count_next   = byte_count_reg;
        sum_acc_next      = sum_acc_reg;
        high_byte_next    = high_byte_reg;
        version_ihl_next  = version_ihl_reg;
        total_len_next    = total_len_reg;
        frag_word_next    = frag_word_reg;
        foreign_flag_next = foreign_flag_reg;
        if (step)
        begin
            if (word.last)
            begin
                byte_count_next   = '0;
                sum_acc_next      = '0;
                high_byte_next    = '0;
                version_ihl_next  = '0;
                total_len_next    = '0;
                frag_word_next    = '0;
                foreign_flag_next = 1'b0;
            end
            else
            begin
                byte_count_next   = count_upd;
                sum_acc_next      = sum_upd;
                high_byte_next    = high_upd;
                version_ihl_next  = version_upd;
                total_len_next    = total_upd;
                frag_word_next    = frag_upd;
                foreign_flag_next = foreign_upd;
            end
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            sum_acc_reg      <= '0;
            high_byte_reg    <= '0;
            version_ihl_reg  <= '0;
            total_len_reg    <= '0;
            frag_word_reg    <= '0;
            foreign_flag_reg <= 1'b0;
        end
        else
        begin
            byte_count_reg   <= byte_count_next;
            sum_acc_reg      <= sum_acc_next;
            high_byte_reg    <= high_byte_next;
            version_ihl_reg  <= version_ihl_next;
            total_len_reg    <= total_len_next;
            frag_word_reg    <= frag_word_next;
            foreign_flag_reg <= foreign_flag_next;
        end
    end

    // a frame's last byte leaves the counter at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        step && word.last |=> byte_count_reg == '0)
        else $error("byte count not cleared after last byte");

    // the host flag is only taken from the first byte of a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        step && !word.last && (byte_count_reg != '0) |=> $stable(foreign_flag_reg))
        else $error("host flag changed inside a frame");

endmodule

// ===== design/ipv4_rx_header_check.sv =====
`timescale 1ns / 1ps
// ipv4 receive header check, top level: input register, frame checker, verdict register
// a last byte is held in the input register, then its verdict is registered in the verdict register
// throughput: one byte per cycle, held back only when a verdict waits and the byte is a last
// the input register and verdict register each hold one word; the frame state is one pass
// reset (rst_n, async, active low) empties both registers and clears all frame state
module ipv4_rx_header_check (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    rx_valid,
    output logic                    rx_ready,
    input  ipv4hc_pkg::ipv4hc_in_t  rx_word,
    output logic                    res_valid,
    input  logic                    res_ready,
    output ipv4hc_pkg::ipv4hc_out_t res_word
);
    import ipv4hc_pkg::*;

    logic        in_valid_reg;
    ipv4hc_in_t  in_word_reg;
    logic        res_valid_reg, res_valid_next;
    ipv4hc_out_t res_word_reg;
    ipv4hc_out_t verdict;
    logic        res_free;
    logic        step;

    // a byte moves on unless it is a last byte and the verdict slot is full
    assign res_free = !res_valid_reg || res_ready;
    assign step     = in_valid_reg && (!in_word_reg.last || res_free);
    assign rx_ready = !in_valid_reg || step;

    ipv4hc_frame u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .word    (in_word_reg),
        .verdict (verdict)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx_ready)
        begin
            in_valid_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            in_word_reg <= rx_word;
        end
    end

    // verdict register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (step && in_word_reg.last)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_word_reg.last)
        begin
            res_word_reg <= verdict;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    // every last byte that moves on produces a verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        step && in_word_reg.last |=> res_valid_reg)
        else $error("last byte gave no verdict");

    // a verdict only follows a last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(step && in_word_reg.last))
        else $error("verdict without a last byte");

    // trimmed length only on accepted datagrams
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_word_reg.status != ST_WHOLE_OK) &&
        (res_word_reg.status != ST_FRAG_OK) |-> res_word_reg.kept_length == '0)
        else $error("kept length set on a rejected frame");

    // a byte held while the verdict waits must be a last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |-> in_word_reg.last && res_valid_reg && !res_ready)
        else $error("input stalled without cause");

endmodule
